[design/bsst_pkg.sv]
package bsst_pkg;

   // Number of cells in the sorted chain; one stored value per cell.
   localparam int CAP_MAX     = 1024;
   localparam int VAL_W       = 32;
   localparam int CNT_W       = 11;
   localparam int GAP_W       = VAL_W + 1;
   localparam int GROUP_SIZE  = 32;
   localparam int GROUP_COUNT = CAP_MAX / GROUP_SIZE;

   localparam logic [VAL_W-1:0] SIGN_FLIP = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic [GAP_W-1:0] GAP_NONE  = {GAP_W{1'b1}};
   localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(CAP_MAX);

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_RANGE = 2'd2;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             spans_valid;
      logic [VAL_W-1:0] shortest_span;
      logic [VAL_W-1:0] longest_span;
      logic [CNT_W-1:0] fill_level;
   } rsp_type;

   // Neighbor gaps of the last inserted key, one insert behind the chain.
   typedef struct packed {
      logic             pred_any;
      logic             succ_any;
      logic [VAL_W-1:0] pred_gap;
      logic [VAL_W-1:0] succ_gap;
   } gap_type;

endpackage

[design/bsst_cell.sv]
module bsst_cell (
   input  logic                      clock,
   input  logic                      ins,
   input  logic                      occ,
   input  logic [bsst_pkg::VAL_W-1:0] key,
   input  logic [bsst_pkg::VAL_W-1:0] left_value,
   input  logic                      left_gt,
   input  logic                      right_gt,
   output logic [bsst_pkg::VAL_W-1:0] value,
   output logic                      gt,
   output logic                      is_pred,
   output logic                      is_succ,
   output logic [bsst_pkg::VAL_W-1:0] pred_gap,
   output logic [bsst_pkg::VAL_W-1:0] succ_gap
);
   import bsst_pkg::*;

   logic [VAL_W-1:0] value_ff;
   logic [VAL_W-1:0] value_in;
   logic [VAL_W-1:0] diff;

   // An empty cell counts as greater than any key.
   assign gt      = !occ || (value_ff > key);
   assign diff    = key - value_ff;
   assign is_pred = occ && !gt && right_gt;
   assign is_succ = occ && gt && !left_gt;
   assign pred_gap = is_pred ? diff : '0;
   assign succ_gap = is_succ ? (value_ff - key) : '0;
   assign value    = value_ff;

   // Shift right where greater; the first greater cell takes the key.
   always_comb begin
      value_in = value_ff;
      if (ins && gt) begin
         value_in = left_gt ? left_value : key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[design/bsst_chain.sv]
module bsst_chain (
   input  logic                      clock,
   input  logic                      ins,
   input  logic [bsst_pkg::VAL_W-1:0] key,
   input  logic [bsst_pkg::CNT_W-1:0] fill,
   output bsst_pkg::gap_type         gap
);
   import bsst_pkg::*;

   logic [VAL_W-1:0] value    [CAP_MAX];
   logic [VAL_W-1:0] pred_gap [CAP_MAX];
   logic [VAL_W-1:0] succ_gap [CAP_MAX];
   logic             gt       [CAP_MAX];
   logic             is_pred  [CAP_MAX];
   logic             is_succ  [CAP_MAX];
   logic             occ      [CAP_MAX];

   logic [VAL_W-1:0] grp_pred_ff     [GROUP_COUNT];
   logic [VAL_W-1:0] grp_succ_ff     [GROUP_COUNT];
   logic             grp_pred_any_ff [GROUP_COUNT];
   logic             grp_succ_any_ff [GROUP_COUNT];
   logic [VAL_W-1:0] grp_pred_in     [GROUP_COUNT];
   logic [VAL_W-1:0] grp_succ_in     [GROUP_COUNT];
   logic             grp_pred_any_in [GROUP_COUNT];
   logic             grp_succ_any_in [GROUP_COUNT];

   for (genvar i = 0; i < CAP_MAX; i++) begin : g_cell
      assign occ[i] = CNT_W'(i) < fill;
      if (i == 0) begin : g_first
         bsst_cell u_cell (
            .clock      (clock),
            .ins        (ins),
            .occ        (occ[i]),
            .key        (key),
            .left_value (key),
            .left_gt    (1'b0),
            .right_gt   (gt[i+1]),
            .value      (value[i]),
            .gt         (gt[i]),
            .is_pred    (is_pred[i]),
            .is_succ    (is_succ[i]),
            .pred_gap   (pred_gap[i]),
            .succ_gap   (succ_gap[i])
         );
      end else if (i == CAP_MAX - 1) begin : g_last
         bsst_cell u_cell (
            .clock      (clock),
            .ins        (ins),
            .occ        (occ[i]),
            .key        (key),
            .left_value (value[i-1]),
            .left_gt    (gt[i-1]),
            .right_gt   (1'b1),
            .value      (value[i]),
            .gt         (gt[i]),
            .is_pred    (is_pred[i]),
            .is_succ    (is_succ[i]),
            .pred_gap   (pred_gap[i]),
            .succ_gap   (succ_gap[i])
         );
      end else begin : g_mid
         bsst_cell u_cell (
            .clock      (clock),
            .ins        (ins),
            .occ        (occ[i]),
            .key        (key),
            .left_value (value[i-1]),
            .left_gt    (gt[i-1]),
            .right_gt   (gt[i+1]),
            .value      (value[i]),
            .gt         (gt[i]),
            .is_pred    (is_pred[i]),
            .is_succ    (is_succ[i]),
            .pred_gap   (pred_gap[i]),
            .succ_gap   (succ_gap[i])
         );
      end
   end

   // At most one cell flags each neighbor, so OR-combine inside each group.
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_pred_in[g]     = '0;
         grp_succ_in[g]     = '0;
         grp_pred_any_in[g] = 1'b0;
         grp_succ_any_in[g] = 1'b0;
         for (int m = 0; m < GROUP_SIZE; m++) begin
            grp_pred_in[g]     = grp_pred_in[g] | pred_gap[g*GROUP_SIZE + m];
            grp_succ_in[g]     = grp_succ_in[g] | succ_gap[g*GROUP_SIZE + m];
            grp_pred_any_in[g] = grp_pred_any_in[g] | is_pred[g*GROUP_SIZE + m];
            grp_succ_any_in[g] = grp_succ_any_in[g] | is_succ[g*GROUP_SIZE + m];
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_pred_ff     <= grp_pred_in;
      grp_succ_ff     <= grp_succ_in;
      grp_pred_any_ff <= grp_pred_any_in;
      grp_succ_any_ff <= grp_succ_any_in;
   end

   always_comb begin
      gap = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         gap.pred_gap = gap.pred_gap | grp_pred_ff[g];
         gap.succ_gap = gap.succ_gap | grp_succ_ff[g];
         gap.pred_any = gap.pred_any | grp_pred_any_ff[g];
         gap.succ_any = gap.succ_any | grp_succ_any_ff[g];
      end
   end

endmodule

[design/bounded_set_span_tracker_core.sv]
// Bounded multiset of signed 32-bit values with running minimum gap and span.
// A request inserts the run value .. value+count-1 (wrapping modulo 2^32) into
// a sorted chain of 1024 cells, one element per clock; insertion stops once the
// fill level reaches min(capacity, 1024) and the elements already added stay.
// A request passes through the run state, where the cell chain inserts one
// element per cycle, then a flush state that drains the registered
// neighbor-gap reduction before the response strobe shows; a zero count goes
// straight to the flush state. A run clipped at the limit first notices the
// limit in the run state without inserting, then flushes. busy is high from
// acceptance until the response goes out, and the next start may be taken in
// the same cycle that rsp_strobe is high.
// rsp_strobe marks a one-cycle transfer that the receiver cannot stall; capture
// rsp_data in that cycle. csr_write_data sets the capacity and should only be
// written while busy is low. After reset the store is empty and capacity is
// 1024; no clearing pass is needed.
module bounded_set_span_tracker_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  bsst_pkg::req_type         req_data,
   output logic                      rsp_strobe,
   output bsst_pkg::rsp_type         rsp_data,
   input  logic                      csr_write_en,
   input  logic [bsst_pkg::CNT_W-1:0] csr_write_data
);
   import bsst_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [VAL_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [1:0]       status_ff, status_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] min_ff, min_in;
   logic [VAL_W-1:0] max_ff, max_in;
   logic [GAP_W-1:0] gap_ff, gap_in;
   logic [CNT_W-1:0] cap_ff;
   logic             s1_valid_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_ff, rsp_in;

   logic             ins;
   logic [CNT_W-1:0] limit;
   gap_type          gap;

   // Capacity above the chain length saturates at the chain length.
   assign limit = (cap_ff > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : cap_ff;

   bsst_chain u_chain (
      .clock (clock),
      .ins   (ins),
      .key   (key_ff),
      .fill  (count_ff),
      .gap   (gap)
   );

   // Fold the neighbor gaps of the previous insert into the running minimum.
   always_comb begin
      gap_in = gap_ff;
      if (s1_valid_ff) begin
         if (gap.pred_any && ({1'b0, gap.pred_gap} < gap_in)) begin
            gap_in = {1'b0, gap.pred_gap};
         end
         if (gap.succ_any && ({1'b0, gap.succ_gap} < gap_in)) begin
            gap_in = {1'b0, gap.succ_gap};
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      ins           = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               // Keys are held sign-flipped so unsigned order matches signed order.
               key_in = VAL_W'(req_data.value) ^ SIGN_FLIP;
               rem_in = req_data.count;
               if (req_data.count == '0) begin
                  status_in = ST_BAD_RANGE;
                  state_in  = S_FLUSH;
               end else begin
                  status_in = ST_OK;
                  state_in  = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (count_ff >= limit) begin
               // Drop the rest of the run.
               status_in = ST_FULL;
               state_in  = S_FLUSH;
            end else begin
               ins      = 1'b1;
               count_in = count_ff + 1'b1;
               key_in   = key_ff + 1'b1;
               rem_in   = rem_ff - 1'b1;
               if (count_ff == '0) begin
                  min_in = key_ff;
                  max_in = key_ff;
               end else begin
                  if (key_ff < min_ff) begin
                     min_in = key_ff;
                  end
                  if (key_ff > max_ff) begin
                     max_in = key_ff;
                  end
               end
               if (rem_ff == CNT_W'(1)) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            // Last insert's gaps land in gap_in this cycle.
            rsp_strobe_in      = 1'b1;
            rsp_in.status      = status_ff;
            rsp_in.fill_level  = count_ff;
            rsp_in.spans_valid = count_ff >= CNT_W'(2);
            if (count_ff >= CNT_W'(2)) begin
               rsp_in.shortest_span = gap_in[VAL_W-1:0];
               rsp_in.longest_span  = max_ff - min_ff;
            end else begin
               rsp_in.shortest_span = '0;
               rsp_in.longest_span  = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         gap_ff        <= GAP_NONE;
         cap_ff        <= CAP_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         gap_ff        <= gap_in;
         s1_valid_ff   <= ins;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // A finished request always hands its response over as busy drops.
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_strobe)
      else $error("busy dropped without a response transfer");

   // An insert never pushes the fill level past the limit.
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      ins |-> (count_ff < limit))
      else $error("insert while store at limit");

   // A key added next to stored values must find at least one neighbor.
   a_neighbor: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (count_ff >= CNT_W'(2))) |-> (gap.pred_any || gap.succ_any))
      else $error("insert into non-empty store found no neighbor");
`endif

endmodule

[dv/tb_bounded_set_span_tracker_core.sv]
module tb_bounded_set_span_tracker_core;
   import bsst_pkg::*;

   // Longest quiet stretch is one full-length run into an empty store; allow several times that.
   localparam int IDLE_LIMIT  = 5000;
   localparam int PHASES      = 13;
   localparam int PHASE_ITEMS = 104;
   localparam int DIR_ROWS    = 18;

   typedef enum logic {ROW_INSERT, ROW_CAPACITY} row_kind_type;

   // One directed step: either a capacity write (value holds the capacity)
   // or an insert, with the result typed in where it is obvious.
   typedef struct {
      row_kind_type     kind;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
      bit               typed;
      logic [1:0]       status;
      logic             spans_valid;
      logic [VAL_W-1:0] shortest_span;
      logic [VAL_W-1:0] longest_span;
      logic [CNT_W-1:0] fill_level;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // zero-length run on the empty store
      '{ROW_INSERT,   32'h0000_0000, 11'd0,    1, ST_BAD_RANGE, 1'b0, 32'h0, 32'h0, 11'd0},
      // most negative, then most positive value: widest possible span
      '{ROW_INSERT,   32'h8000_0000, 11'd1,    1, ST_OK, 1'b0, 32'h0, 32'h0, 11'd1},
      '{ROW_INSERT,   32'h7FFF_FFFF, 11'd1,    1, ST_OK, 1'b1, 32'hFFFF_FFFF,
        32'hFFFF_FFFF, 11'd2},
      // duplicate value drives the shortest span to zero
      '{ROW_INSERT,   32'h7FFF_FFFF, 11'd1,    1, ST_OK, 1'b1, 32'h0, 32'hFFFF_FFFF, 11'd3},
      // run that wraps past the top of the signed range
      '{ROW_INSERT,   32'h7FFF_FFFE, 11'd4,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'h0000_0000, 11'd0,    1, ST_BAD_RANGE, 1'b1, 32'h0,
        32'hFFFF_FFFF, 11'd7},
      // run that only partly fits
      '{ROW_CAPACITY, 32'd10,        11'd0,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'd100,       11'd8,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'd5,         11'd1,    1, ST_FULL, 1'b1, 32'h0, 32'hFFFF_FFFF, 11'd10},
      // capacity lowered below the fill level
      '{ROW_CAPACITY, 32'd0,         11'd0,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'd7,         11'd1,    1, ST_FULL, 1'b1, 32'h0, 32'hFFFF_FFFF, 11'd10},
      '{ROW_INSERT,   32'd7,         11'd0,    1, ST_BAD_RANGE, 1'b1, 32'h0,
        32'hFFFF_FFFF, 11'd10},
      // longest runs, clipped by a small capacity
      '{ROW_CAPACITY, 32'd20,        11'd0,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'hFFFF_FFF0, 11'd2047, 0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'h0000_0000, 11'd1024, 1, ST_FULL, 1'b1, 32'h0,
        32'hFFFF_FFFF, 11'd20},
      // capacity above the cell count
      '{ROW_CAPACITY, 32'd2047,      11'd0,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'h8000_0000, 11'd1,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0},
      '{ROW_INSERT,   32'h0000_0001, 11'd3,    0, ST_OK, 1'b0, 32'h0, 32'h0, 11'd0}
   };

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             start          = 1'b0;
   logic             busy;
   req_type          req_data       = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_write_en   = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;

   // Shadow of the store: sign-flipped keys kept in ascending order.
   logic [VAL_W-1:0] set_keys[$];
   logic [GAP_W-1:0] gap_min  = GAP_NONE;
   logic [CNT_W-1:0] cap_reg  = CAP_RESET;
   rsp_type          pending_rsp[$];

   int mismatches   = 0;
   int inserts_sent = 0;
   int directed_cnt = 0;
   int clipped_runs = 0;
   int empty_runs   = 0;
   int csr_writes   = 0;
   int idle_cycles  = 0;

   bounded_set_span_tracker_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // Insert the run one key at a time, tracking neighbor gaps of each new key,
   // and work out the result the block should report afterwards.
   task automatic predict_insert(input req_type r, output rsp_type res);
      int unsigned      lim;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      logic [VAL_W-1:0] key;
      logic [VAL_W-1:0] g;
      res = '0;
      res.status = ST_OK;
      lim = (int'(cap_reg) < CAP_MAX) ? int'(cap_reg) : CAP_MAX;
      if (r.count == 0) begin
         res.status = ST_BAD_RANGE;
      end else begin
         key = r.value ^ SIGN_FLIP;
         for (int i = 0; i < r.count; i++) begin
            if (set_keys.size() >= lim) begin
               res.status = ST_FULL;
               break;
            end
            lo = 0;
            hi = set_keys.size();
            while (lo < hi) begin
               mid = lo + (hi - lo) / 2;
               if (set_keys[mid] <= key) lo = mid + 1;
               else hi = mid;
            end
            if (lo > 0) begin
               g = key - set_keys[lo-1];
               if ({1'b0, g} < gap_min) gap_min = {1'b0, g};
            end
            if (lo < set_keys.size()) begin
               g = set_keys[lo] - key;
               if ({1'b0, g} < gap_min) gap_min = {1'b0, g};
            end
            set_keys.insert(lo, key);
            key = key + 1'b1;
         end
      end
      if (set_keys.size() >= 2) begin
         res.spans_valid   = 1'b1;
         res.shortest_span = gap_min[VAL_W-1:0];
         // the flipped sign bit cancels in the difference
         res.longest_span  = set_keys[$] - set_keys[0];
      end
      res.fill_level = CNT_W'(set_keys.size());
   endtask

   // Present one insert after an optional random gap and hold it until the
   // transfer; leave start high so a back-to-back item needs no extra edge.
   task automatic send_insert(input logic [VAL_W-1:0] value, input logic [CNT_W-1:0] count,
                              input bit typed, input rsp_type typed_rsp, input bit gaps);
      req_type r;
      rsp_type e;
      int      gap;
      int      sel;
      r.value = value;
      r.count = count;
      gap = 0;
      if (gaps) begin
         sel = $urandom_range(0, 99);
         if (sel >= 90) gap = $urandom_range(8, 40);
         else if (sel >= 55) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_insert(r, e);
      pending_rsp = {pending_rsp, (typed ? typed_rsp : e)};
      inserts_sent++;
      if (e.status == ST_FULL) clipped_runs++;
      if (e.status == ST_BAD_RANGE) empty_runs++;
   endtask

   // Drop start, drain every outstanding result, then write the capacity.
   task automatic write_capacity(input logic [CNT_W-1:0] v);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cap_reg = v;
      csr_writes++;
   endtask

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer: %p", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.spans_valid !== want.spans_valid ||
                rsp_data.shortest_span !== want.shortest_span ||
                rsp_data.longest_span !== want.longest_span ||
                rsp_data.fill_level !== want.fill_level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: exp st=%0d sv=%0b short=%h long=%h fill=%0d,",
                            " got st=%0d sv=%0b short=%h long=%h fill=%0d"},
                           want.status, want.spans_valid, want.shortest_span,
                           want.longest_span, want.fill_level,
                           rsp_data.status, rsp_data.spans_valid, rsp_data.shortest_span,
                           rsp_data.longest_span, rsp_data.fill_level);
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      rsp_type          t;
      logic [CNT_W-1:0] cap;
      logic [VAL_W-1:0] base;
      logic [VAL_W-1:0] v;
      logic [CNT_W-1:0] n;
      int               sel;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CAPACITY) begin
            write_capacity(dir_rows[i].value[CNT_W-1:0]);
         end else begin
            t.status        = dir_rows[i].status;
            t.spans_valid   = dir_rows[i].spans_valid;
            t.shortest_span = dir_rows[i].shortest_span;
            t.longest_span  = dir_rows[i].longest_span;
            t.fill_level    = dir_rows[i].fill_level;
            send_insert(dir_rows[i].value, dir_rows[i].count, dir_rows[i].typed, t, 1'b1);
            directed_cnt++;
         end
      end

      // Random phases: raise capacity in steps so the store fills gradually
      // and runs get clipped often; one phase lowers it to or below the fill level,
      // the last two use the extremes.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            4:       cap = CNT_W'($urandom_range(0, set_keys.size()));
            11:      cap = 11'd2047;
            12:      cap = CAP_RESET;
            default: cap = CNT_W'(set_keys.size() + $urandom_range(5, 90));
         endcase
         write_capacity(cap);
         base = $urandom;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) v = $urandom;
            else if (sel < 8) v = base + $urandom_range(0, 300) - 32'd150;
            else if (sel == 8) v = 32'h8000_0000 + $urandom_range(0, 3);
            else v = 32'h7FFF_FFFF - $urandom_range(0, 3);
            sel = $urandom_range(0, 99);
            if (sel < 4) n = '0;
            else if (sel < 55) n = 11'd1;
            else if (sel < 90) n = CNT_W'($urandom_range(2, 8));
            else if (sel < 97) n = CNT_W'($urandom_range(9, 64));
            else n = CNT_W'($urandom_range(1000, 2047));
            // every fourth phase runs back to back with no gaps
            send_insert(v, n, 1'b0, '0, (p % 4) != 2);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d inserts (%0d directed): %0d clipped at capacity, %0d zero-length",
               inserts_sent, directed_cnt, clipped_runs, empty_runs);
      $display("store ended at %0d values after %0d capacity writes, %0d mismatches",
               set_keys.size(), csr_writes, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
